/* hw/rtl/srle_pkg.sv */
`default_nettype none

package srle_pkg;

    // Segment kind that announces a run of literal pixel bytes.
    localparam logic [7:0] LITERAL_KIND = 8'hFF;

    // Configuration register indexes.
    localparam int         REG_INDEX_W      = 1;
    localparam int         CFG_DATA_W       = 13;
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // Depth of the command queue between the parser and the emitter.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_LIT
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } seg_item_t;

    typedef struct packed {
        logic [24:0] write_address;
        logic [7:0]  pixel_value;
        logic [8:0]  run_length;
        logic        row_done;
        logic        image_done;
        logic        row_overrun;
    } wr_item_t;

    // One parsed command: a restart marker and/or one write of a run.
    typedef struct packed {
        logic       restart;
        logic       write;
        logic [7:0] value;
        logic [8:0] len;
        logic       seg_end;
    } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/srle_front.sv */
`default_nettype none

module srle_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seg_valid,
    output logic              seg_stall,
    input  srle_pkg::seg_item_t seg,
    input  logic              q_full,
    output logic              cmd_push,
    output srle_pkg::cmd_t    cmd
);
    import srle_pkg::*;

    phase_t     phase_reg, phase_next, phase_cur;
    logic [7:0] kind_reg, kind_next, kind_cur;
    logic [8:0] left_reg, left_next, left_cur, left_dec;
    logic       accept;

    assign seg_stall = q_full;
    assign accept    = seg_valid && !q_full;

    // A restart byte is parsed as though the state had just been cleared.
    assign phase_cur = seg.image_start ? PH_KIND : phase_reg;
    assign kind_cur  = seg.image_start ? 8'd0 : kind_reg;
    assign left_cur  = seg.image_start ? 9'd0 : left_reg;
    assign left_dec  = left_cur - 9'd1;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        if (accept)
        begin
            phase_next = phase_cur;
            kind_next  = kind_cur;
            left_next  = left_cur;
            case (phase_cur)
                PH_KIND:
                begin
                    kind_next  = seg.data_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (kind_cur == LITERAL_KIND)
                    begin
                        left_next  = {1'b0, seg.data_byte} + 9'd1;
                        phase_next = PH_LIT;
                    end
                    else
                    begin
                        phase_next = PH_KIND;
                    end
                end
                PH_LIT:
                begin
                    left_next  = left_dec;
                    phase_next = (left_dec == 9'd0) ? PH_KIND : PH_LIT;
                end
                default:
                begin
                    phase_next = PH_KIND;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.restart = seg.image_start;
        cmd.write   = 1'b0;
        cmd.value   = kind_cur;
        cmd.len     = {1'b0, seg.data_byte} + 9'd1;
        cmd.seg_end = 1'b1;
        case (phase_cur)
            PH_LEN:
            begin
                cmd.write = (kind_cur != LITERAL_KIND);
            end
            PH_LIT:
            begin
                cmd.write   = 1'b1;
                cmd.value   = seg.data_byte;
                cmd.len     = 9'd1;
                cmd.seg_end = (left_dec == 9'd0);
            end
            default:
            begin
                cmd.write = 1'b0;
            end
        endcase
        cmd_push = accept && (cmd.restart || cmd.write);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            kind_reg  <= 8'd0;
            left_reg  <= 9'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/srle_queue.sv */
`default_nettype none

module srle_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  srle_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output srle_pkg::cmd_t head_cmd
);
    import srle_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    // Depth is a power of two, so the pointers wrap on their own.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/srle_back.sv */
`default_nettype none

module srle_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [12:0]         image_width,
    input  logic [12:0]         image_height,
    input  logic                cmd_valid,
    input  srle_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                wr_valid,
    input  logic                wr_stall,
    output srle_pkg::wr_item_t  wr
);
    import srle_pkg::*;

    logic [13:0] column_reg, column_next, col_cur, col_sum;
    logic [12:0] row_reg, row_next, row_cur;
    logic [23:0] base_reg, base_next, base_cur;
    logic        done_reg, done_next, done_cur;
    logic        wr_valid_reg, wr_valid_next;
    wr_item_t    wr_reg, wr_next;

    logic [12:0] eff_w, eff_h;
    logic [13:0] width_ext, stride_sum, stride;
    logic        take, emit, row_end, last_row, overrun;

    always_comb
    begin
        if (int'(image_width) > MAX_WIDTH)
            eff_w = 13'(MAX_WIDTH);
        else
            eff_w = image_width;

        if (image_height == 13'd0)
            eff_h = 13'd1;
        else if (int'(image_height) > MAX_HEIGHT)
            eff_h = 13'(MAX_HEIGHT);
        else
            eff_h = image_height;
    end

    assign width_ext  = {1'b0, eff_w};
    assign stride_sum = width_ext + 14'd3;
    assign stride     = {stride_sum[13:2], 2'b00};

    assign take    = cmd_valid && (!wr_valid_reg || !wr_stall);
    assign cmd_pop = take;

    // A restart clears the row position before the command is applied.
    assign col_cur  = cmd.restart ? 14'd0 : column_reg;
    assign row_cur  = cmd.restart ? 13'd0 : row_reg;
    assign base_cur = cmd.restart ? 24'd0 : base_reg;
    assign done_cur = cmd.restart ? 1'b0  : done_reg;

    assign col_sum  = col_cur + 14'(cmd.len);
    assign overrun  = (col_sum > width_ext);
    assign row_end  = cmd.seg_end && (col_sum >= width_ext);
    assign last_row = ({1'b0, row_cur} + 14'd1) >= {1'b0, eff_h};
    assign emit     = cmd.write && !done_cur;

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        base_next   = base_reg;
        done_next   = done_reg;
        if (take)
        begin
            column_next = col_cur;
            row_next    = row_cur;
            base_next   = base_cur;
            done_next   = done_cur;
            if (emit)
            begin
                column_next = row_end ? 14'd0 : col_sum;
                if (row_end)
                begin
                    row_next  = row_cur + 13'd1;
                    base_next = base_cur + 24'(stride);
                    done_next = last_row;
                end
            end
        end
    end

    always_comb
    begin
        wr_next.write_address = 25'(base_cur) + 25'(col_cur);
        wr_next.pixel_value   = cmd.value;
        wr_next.run_length    = cmd.len;
        wr_next.row_done      = row_end;
        wr_next.image_done    = row_end && last_row;
        wr_next.row_overrun   = overrun;

        if (take && emit)
            wr_valid_next = 1'b1;
        else if (!wr_stall)
            wr_valid_next = 1'b0;
        else
            wr_valid_next = wr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= 14'd0;
            row_reg      <= 13'd0;
            base_reg     <= 24'd0;
            done_reg     <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            base_reg     <= base_next;
            done_reg     <= done_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            wr_reg <= wr_next;
        end
    end

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

endmodule

`default_nettype wire

/* hw/rtl/segment_rle_row_decoder.sv */
// Path: a byte that completes a write is pushed into the command queue as it is
// accepted; the back registers its write beat once the output register is free.
// Throughput: one byte per cycle, sustained, while the write side keeps up; the
// emitter retires one queued command per cycle and sets that figure.
// Reset: rst_n is asynchronous and active low; it clears the parser, the queue and
// the row position, and sets image_width and image_height to one.
`default_nettype none

module segment_rle_row_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    seg_valid,
    output logic                                    seg_stall,
    input  srle_pkg::seg_item_t                     seg,

    output logic                                    wr_valid,
    input  logic                                    wr_stall,
    output srle_pkg::wr_item_t                      wr,

    input  logic                                    cfg_write_enable,
    input  logic [srle_pkg::REG_INDEX_W-1:0]        cfg_index,
    input  logic [srle_pkg::CFG_DATA_W-1:0]         cfg_write_data
);
    import srle_pkg::*;

    // The design is split in two halves joined by a short command queue.
    // The front parses the byte stream (kind byte, length byte, literal
    // bytes) and turns each byte into at most one command: a fill run, a
    // single literal pixel, or a restart marker when image_start is set.
    // The back keeps the row position (column, row index, row base address)
    // and turns commands into write beats held in an output register. The
    // queue lets the front keep taking bytes while a write beat is stalled.
    //
    // Once the last row has been written the back drops further writes
    // until a restart marker arrives; the front keeps parsing meanwhile,
    // which is harmless because a restart resets its state as well.

    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;

    logic q_full;
    logic cmd_push;
    cmd_t front_cmd;
    logic cmd_pop;
    logic head_valid;
    cmd_t head_cmd;

    // Configuration registers; an unknown index is ignored.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_write_data;
                REG_IMAGE_HEIGHT: height_next = cfg_write_data;
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    srle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .q_full    (q_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    srle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    srle_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .wr_valid     (wr_valid),
        .wr_stall     (wr_stall),
        .wr           (wr)
    );

endmodule

`default_nettype wire

/* hw/rtl/srle_checker.sv */
`default_nettype none

module srle_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               seg_valid,
    input  wire logic                               seg_stall,
    input  wire srle_pkg::seg_item_t                seg,
    input  wire logic                               wr_valid,
    input  wire logic                               wr_stall,
    input  wire srle_pkg::wr_item_t                 wr,
    input  wire logic                               cfg_write_enable,
    input  wire logic [srle_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  wire logic [srle_pkg::CFG_DATA_W-1:0]    cfg_write_data
);

    // A stalled write beat stays offered and unchanged.
    a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_stall |=> wr_valid && $stable(wr))
        else $error("write beat dropped or changed while stalled");

    // Finishing the image always finishes a row.
    a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid |-> (!wr.image_done || wr.row_done))
        else $error("image_done without row_done");

    // Every write covers at least one pixel.
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid |-> (wr.run_length != 9'd0))
        else $error("write beat with zero run length");

    // Once reset has been seen at an edge, nothing is offered and no byte is held off.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> (!wr_valid && !seg_stall))
        else $error("handshake active during reset");

endmodule

bind segment_rle_row_decoder srle_checker u_srle_checker (.*);

`default_nettype wire

/* test/segment_rle_row_decoder_tb.sv */
`timescale 1ns / 1ps

// Testbench for the segment run-length row decoder.
//
// Segment bytes go in one beat at a time on the seg channel. A predictor in this
// module follows the same bytes and works out the write beat that each byte
// should produce. Each write beat that leaves the block is checked, field by
// field, against the oldest prediction still waiting.
//
// Both channels use valid and stall. Inputs are driven with nonblocking
// assignments at the rising edge. Handshakes are sampled at the falling edge,
// when everything has settled, and a beat seen there counts as accepted at the
// following rising edge.
module segment_rle_row_decoder_tb;
    import srle_pkg::*;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;

    // The write beat passes the command queue and the output register after the byte;
    // the wait allows for that before the registers are touched.
    localparam int SETTLE_CYCLES = 4;

    // Longest quiet stretch is the receiver hold-off.
    localparam int QUIET_LIMIT = 3000;

    logic                  clk;
    logic                  rst_n;
    logic                  seg_valid;
    logic                  seg_stall;
    seg_item_t             seg;
    logic                  wr_valid;
    logic                  wr_stall;
    wr_item_t              wr;
    logic                  cfg_write_enable;
    logic [REG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_write_data;

    // Idling rates in percent and the receiver hold-off counter.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_cycles = 0;

    // Predictor state: our copy of the registers and the decoding position.
    logic [CFG_DATA_W-1:0] cfg_width      = 13'd1;
    logic [CFG_DATA_W-1:0] cfg_height     = 13'd1;
    phase_t                parse_at       = PH_KIND;
    bit                    image_finished = 1'b0;
    logic [7:0]            seg_kind       = 8'h00;
    int unsigned           literal_left   = 0;
    int unsigned           pos_column     = 0;
    int unsigned           pos_row        = 0;
    int unsigned           row_base       = 0;

    // Write beats that the predictor expects, oldest first.
    wr_item_t    expected_writes[$];
    int unsigned decoded_bytes  = 0;
    int unsigned writes_checked = 0;
    int unsigned mismatches     = 0;

    segment_rle_row_decoder #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .seg_valid        (seg_valid),
        .seg_stall        (seg_stall),
        .seg              (seg),
        .wr_valid         (wr_valid),
        .wr_stall         (wr_stall),
        .wr               (wr),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_write_data   (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Widths above the maximum saturate to it.
    function automatic int unsigned eff_width();
        return (cfg_width > MAX_W) ? MAX_W : cfg_width;
    endfunction

    // A height of zero still means one row; large heights saturate.
    function automatic int unsigned eff_height();
        if (cfg_height == 0)
            return 1;
        return (cfg_height > MAX_H) ? MAX_H : cfg_height;
    endfunction

    // Follows one accepted byte and queues the write beat it causes, if any.
    function automatic void predict_byte(input logic [7:0] value, input logic start);
        int unsigned w;
        int unsigned stride;
        int unsigned count;
        int unsigned addr;
        logic [7:0]  pixel;
        bit          closes;
        bit          writes;
        wr_item_t    want;
        if (start)
        begin
            parse_at       = PH_KIND;
            image_finished = 1'b0;
            seg_kind       = 8'h00;
            literal_left   = 0;
            pos_column     = 0;
            pos_row        = 0;
            row_base       = 0;
        end
        // Once the last row is out, bytes are dropped until the next restart.
        if (image_finished)
            return;
        decoded_bytes++;
        writes = 1'b0;
        case (parse_at)
            PH_KIND:
            begin
                seg_kind = value;
                parse_at = PH_LEN;
            end
            PH_LEN:
            begin
                if (seg_kind == LITERAL_KIND)
                begin
                    literal_left = value + 1;
                    parse_at     = PH_LIT;
                end
                else
                begin
                    // A fill segment comes out as one run write.
                    pixel  = seg_kind;
                    count  = value + 1;
                    closes = 1'b1;
                    writes = 1'b1;
                end
            end
            default:
            begin
                literal_left = (literal_left - 1) & 32'h1FF;
                pixel        = value;
                count        = 1;
                closes       = (literal_left == 0);
                writes       = 1'b1;
            end
        endcase
        if (!writes)
            return;

        w      = eff_width();
        stride = (w + 3) & ~32'd3;
        addr   = (row_base + pos_column) & 32'h1FF_FFFF;
        pos_column += count;

        want.write_address = addr[24:0];
        want.pixel_value   = pixel;
        want.run_length    = count[8:0];
        want.row_overrun   = (pos_column > w);
        want.row_done      = 1'b0;
        want.image_done    = 1'b0;
        // A row only ends at the close of a segment, even one that overshoots.
        if (closes)
        begin
            parse_at = PH_KIND;
            if (pos_column >= w)
            begin
                want.row_done = 1'b1;
                pos_column    = 0;
                if (pos_row + 1 >= eff_height())
                begin
                    want.image_done = 1'b1;
                    image_finished  = 1'b1;
                end
                pos_row++;
                row_base = (row_base + stride) & 32'hFF_FFFF;
            end
        end
        pos_column &= 32'h1_FFFF;
        expected_writes.push_back(want);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("write beat %0d, %s is 0x%0h, expected 0x%0h",
                                      writes_checked, name, got, want));
    endtask

    // A write beat seen here with stall low is accepted at the next rising edge.
    always @(negedge clk)
    begin : write_checker
        wr_item_t want;
        if (rst_n && wr_valid === 1'b1 && wr_stall === 1'b0)
        begin
            if (expected_writes.size() == 0)
                report_mismatch($sformatf("write beat to 0x%0h with nothing expected",
                                          wr.write_address));
            else
            begin
                want = expected_writes.pop_front();
                check_field("write_address", wr.write_address, want.write_address);
                check_field("pixel_value",   wr.pixel_value,   want.pixel_value);
                check_field("run_length",    wr.run_length,    want.run_length);
                check_field("row_done",      wr.row_done,      want.row_done);
                check_field("image_done",    wr.image_done,    want.image_done);
                check_field("row_overrun",   wr.row_overrun,   want.row_overrun);
            end
            writes_checked++;
        end
    end

    // The receiver stalls at random, or for a whole hold-off that it counts down
    // itself once a test asks for one.
    initial
    begin : write_receiver
        wr_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                wr_stall <= 1'b1;
                hold_cycles--;
            end
            else
                wr_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Ends the run if nothing moves on any port for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((seg_valid && seg_stall === 1'b0) || (wr_valid === 1'b1 && !wr_stall)
                || cfg_write_enable)
                quiet = 0;
            else
                quiet++;
        end
        $display("** segment_rle_row_decoder: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one byte, possibly after some idle cycles, and returns at the edge
    // where it is accepted. Valid stays high so the next beat can follow at once.
    task automatic send_byte(input logic [7:0] value, input logic start);
        seg_item_t item;
        item.data_byte   = value;
        item.image_start = start;
        while ($urandom_range(99) < send_idle_pct)
        begin
            seg_valid <= 1'b0;
            @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg       <= item;
        @(negedge clk);
        while (seg_stall !== 1'b0)
            @(negedge clk);
        @(posedge clk);
        predict_byte(value, start);
    endtask

    // One whole segment: kind, length and, for literals, the pixel bytes.
    task automatic send_segment(input logic [7:0] kind, input int unsigned count,
                                input logic start);
        send_byte(kind, start);
        send_byte(8'(count - 1), 1'b0);
        if (kind == LITERAL_KIND)
            repeat (count) send_byte(8'($urandom), 1'b0);
    endtask

    // The sender goes quiet until every predicted write has arrived, then waits
    // out the pipeline so that bytes with no write are done with too.
    task automatic wait_drained();
        seg_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the width register and then the height register. Only call this while idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height);
        cfg_write_enable <= 1'b1;
        cfg_index        <= REG_IMAGE_WIDTH;
        cfg_write_data   <= width;
        @(posedge clk);
        cfg_index        <= REG_IMAGE_HEIGHT;
        cfg_write_data   <= height;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        cfg_width  = width;
        cfg_height = height;
        @(posedge clk);
    endtask

    // Sends one image of random segments, starting with a restart. Most segments
    // fit what is left of the row; some overshoot it, and now and then a segment
    // is cut short after its kind byte so that the next image restarts mid-segment.
    task automatic send_image(input int budget);
        int unsigned room;
        int unsigned count;
        logic [7:0]  kind;
        bit          first;
        first = 1'b1;
        while (budget > 0 && (first || !image_finished))
        begin
            room = (pos_column < eff_width()) ? eff_width() - pos_column : 0;
            if (room == 0 || $urandom_range(9) == 0)
                count = $urandom_range(1, 256);
            else
                count = $urandom_range(1, (room > 256) ? 256 : room);
            if ($urandom_range(9) < 3)
            begin
                kind = LITERAL_KIND;
                if (count > 12)
                    count = $urandom_range(1, 12);
            end
            else
                kind = 8'($urandom_range(0, 254));
            if ($urandom_range(39) == 0)
            begin
                send_byte(kind, first);
                break;
            end
            send_segment(kind, count, first);
            first = 1'b0;
            budget -= (kind == LITERAL_KIND) ? count + 2 : 2;
        end
        // Trailing bytes after a finished image must be dropped.
        if (image_finished)
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked bytes: reset register values, literal and fill segments at the
    // extremes of kind, length and pixel, an overshooting last segment, bytes
    // after the image, restarts in the length and literal phases, and a width
    // and height of zero.
    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        wait_drained();

        configure(13'd8, 13'd2);
        send_byte(LITERAL_KIND, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h04, 1'b0);
        // Second row: a 256-pixel fill runs far past the width.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);

        // Restart while the length byte is awaited.
        send_byte(8'h33, 1'b1);
        send_byte(8'h44, 1'b1);
        send_byte(8'h01, 1'b0);

        // Restart in the middle of a literal segment.
        send_byte(LITERAL_KIND, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h10, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_drained();

        configure(13'd0, 13'd0);
        send_byte(8'h07, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_drained();
    endtask

    // Random images in three idling regimes. Mostly small images that finish,
    // some narrow or zero-width ones, some mid-sized, and a few near or past the
    // largest size, which only get partly decoded.
    task automatic test_random_images();
        int unsigned target;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        bit          fresh;
        for (int m = 0; m < 3; m++)
        begin
            send_idle_pct = (m == 0) ? 22 : (m == 1) ? 88 : 0;
            recv_idle_pct = (m == 0) ? 88 : (m == 1) ? 22 : 0;
            target = decoded_bytes + 90;
            fresh  = 1'b1;
            while (decoded_bytes < target)
            begin
                if (fresh || $urandom_range(1) == 0)
                begin
                    pick = $urandom_range(99);
                    if (pick < 60)
                    begin
                        w = $urandom_range(1, 40);
                        h = $urandom_range(1, 4);
                    end
                    else if (pick < 75)
                    begin
                        w = $urandom_range(0, 4);
                        h = $urandom_range(0, 3);
                    end
                    else if (pick < 88)
                    begin
                        w = $urandom_range(41, 600);
                        h = $urandom_range(1, 3);
                    end
                    else
                    begin
                        w = $urandom_range(4090, 8191);
                        h = $urandom_range(4090, 8191);
                    end
                    wait_drained();
                    configure(13'(w), 13'(h));
                    fresh = 1'b0;
                end
                send_image($urandom_range(20, 80));
            end
        end
    endtask

    // The receiver holds off for a long stretch while a long literal segment keeps
    // coming, so the block fills up and has to stall the byte side.
    task automatic test_backpressure();
        wait_drained();
        configure(13'd8191, 13'd1);
        hold_cycles = 300;
        send_segment(LITERAL_KIND, 60, 1'b1);
        send_segment(8'h5A, 200, 1'b0);
        wait_drained();
    endtask

    // The sender pauses mid-row until every write is out, then carries on with
    // the same image, so the decoding position must survive an empty pipeline.
    task automatic test_drain_pause();
        wait_drained();
        configure(13'd100, 13'd8191);
        for (int k = 0; k < 6; k++)
        begin
            send_segment(8'($urandom_range(0, 254)), $urandom_range(1, 30), k == 0);
            send_segment(LITERAL_KIND, $urandom_range(1, 6), 1'b0);
            wait_drained();
        end
    endtask

    initial
    begin : stimulus
        rst_n            = 1'b0;
        seg_valid        = 1'b0;
        seg              = '0;
        cfg_write_enable = 1'b0;
        cfg_index        = '0;
        cfg_write_data   = '0;
        send_idle_pct    = 22;
        recv_idle_pct    = 88;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_images();
        test_backpressure();
        test_drain_pause();

        wait_drained();
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("** segment_rle_row_decoder: PASSED **");
        else
            $display("** segment_rle_row_decoder: FAILED **");
        $finish;
    end

endmodule
